// File: src/assert_macros.svh
// assertion macros used by the rtl top file
// clocked check with reset disable, and clocked check that also runs in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: src/fwk_pkg.sv
// ============================================================================
// fwk_pkg
// Shared widths, constants, controller states and the control/status structs
// of the binary indexed tree range-sum block.
// ============================================================================
package fwk_pkg;

    localparam int SUM_W   = 64;
    localparam int AMT_W   = 32;
    localparam int POS_W   = 10;
    localparam int RANGE_W = 11;
    localparam int SIZE_W  = 11;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ADD_RD,
        S_ADD_WR,
        S_QR_RD,
        S_QR_ACC,
        S_QL_RD,
        S_QL_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;      // capture request, start walk
        logic clr_wr;    // write zero during clearing pass
        logic rd;        // read node idx
        logic add_wr;    // write node plus amount, step up
        logic acc;       // fold read node into sum, step down
        logic acc_sub;   // subtract instead of add
        logic load_left; // restart walk from left bound
        logic done;      // present result
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic err;
        logic is_query;
        logic idx_zero;
        logic idx_over;
    } t_dp_status;

endpackage

// File: src/fenwick_range_sum.sv
// ============================================================================
// fenwick_range_sum
// Binary indexed tree of 64-bit partial sums with point add and half-open
// range-sum query, one request at a time over a single-port store.
// ============================================================================
// steps: an add reads and writes each node on the upward walk, k = nodes on
//   the walk (up to log2(size) + 1); a query folds in the nodes of right,
//   then subtracts those of left; a flagged request goes straight to the result
// requests: handled one at a time
// reset: synchronous; a clearing pass then zeroes the store with busy high;
//   results are strobed and cannot be stalled
// ============================================================================
`include "assert_macros.svh"

module fenwick_range_sum #(
    parameter int MAX_ENTRIES = fwk_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_req_type,
    input  logic [fwk_pkg::POS_W-1:0]        i_add_position,
    input  logic signed [fwk_pkg::AMT_W-1:0] i_add_amount,
    input  logic [fwk_pkg::RANGE_W-1:0]      i_range_left,
    input  logic [fwk_pkg::RANGE_W-1:0]      i_range_right,
    output logic                             o_result_valid,
    output logic signed [fwk_pkg::SUM_W-1:0] o_range_sum,
    output logic                             o_index_error,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fwk_pkg::SIZE_W-1:0]       i_cfg_data
);
    import fwk_pkg::*;

    t_dp_cmd    s_cmd;
    t_dp_status s_status;

    assign o_cfg_ready = 1'b1;

    fwk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (s_status),
        .o_cmd    (s_cmd),
        .o_busy   (busy)
    );

    fwk_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_status       (s_status),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_add_position (i_add_position),
        .i_add_amount   (i_add_amount),
        .i_range_left   (i_range_left),
        .i_range_right  (i_range_right),
        .o_result_valid (o_result_valid),
        .o_range_sum    (o_range_sum),
        .o_index_error  (o_index_error)
    );

    // a result only follows a busy cycle
    `ASSERT_CLK(a_strobe_after_busy, i_clk, i_rst_n, o_result_valid |-> $past(busy))
    // accepted request keeps the block busy next cycle
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    // flagged request reads nothing and gives zero
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n, o_result_valid && o_index_error |-> o_range_sum == '0)
    // no result while the store is being cleared
    `ASSERT_CLK(a_no_result_in_clear, i_clk, i_rst_n, s_cmd.clr_wr |-> !o_result_valid)
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_result_valid)

endmodule

// File: src/fwk_ctrl.sv
// ============================================================================
// fwk_ctrl
// Sequencer: clearing pass after reset, then one request at a time through
// the upward add walk or the two downward prefix walks, or straight to done.
// ============================================================================
module fwk_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  fwk_pkg::t_dp_status i_status,
    output fwk_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);
    import fwk_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_status.err)           n_state = S_DONE;
                else if (i_status.is_query) n_state = S_QR_RD;
                else                        n_state = S_ADD_RD;
            end
            S_ADD_RD: begin
                n_state = i_status.idx_over ? S_DONE : S_ADD_WR;
            end
            S_ADD_WR: n_state = S_ADD_RD;
            S_QR_RD: begin
                n_state = i_status.idx_zero ? S_QL_RD : S_QR_ACC;
            end
            S_QR_ACC: n_state = S_QR_RD;
            S_QL_RD: begin
                n_state = i_status.idx_zero ? S_DONE : S_QL_ACC;
            end
            S_QL_ACC: n_state = S_QL_RD;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_DISPATCH: ;
            S_ADD_RD: o_cmd.rd = !i_status.idx_over;
            S_ADD_WR: o_cmd.add_wr = 1'b1;
            S_QR_RD: begin
                o_cmd.rd        = !i_status.idx_zero;
                o_cmd.load_left = i_status.idx_zero;
            end
            S_QR_ACC: o_cmd.acc = 1'b1;
            S_QL_RD:  o_cmd.rd = !i_status.idx_zero;
            S_QL_ACC: begin
                o_cmd.acc     = 1'b1;
                o_cmd.acc_sub = 1'b1;
            end
            S_DONE:  o_cmd.done = 1'b1;
            default: ;
        endcase
    end

endmodule

// File: src/fwk_dp.sv
// ============================================================================
// fwk_dp
// Datapath: single-port partial-sum store, tree index walker, 64-bit
// accumulator, size register and result registers.
// ============================================================================
module fwk_dp #(
    parameter int MAX_ENTRIES = fwk_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fwk_pkg::t_dp_cmd                 i_cmd,
    output fwk_pkg::t_dp_status              o_status,
    input  logic                             i_cfg_valid,
    input  logic [fwk_pkg::SIZE_W-1:0]       i_cfg_data,
    input  logic                             i_req_type,
    input  logic [fwk_pkg::POS_W-1:0]        i_add_position,
    input  logic signed [fwk_pkg::AMT_W-1:0] i_add_amount,
    input  logic [fwk_pkg::RANGE_W-1:0]      i_range_left,
    input  logic [fwk_pkg::RANGE_W-1:0]      i_range_right,
    output logic                             o_result_valid,
    output logic signed [fwk_pkg::SUM_W-1:0] o_range_sum,
    output logic                             o_index_error
);
    import fwk_pkg::*;

    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW0 = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    // one spare bit so the upward walk can step past n
    localparam int IW  = NW0 + 1;
    localparam logic [IW-1:0] MAX_N    = IW'(MAX_ENTRIES);
    localparam logic [AW-1:0] LAST_ADR = AW'(MAX_ENTRIES - 1);

    logic [SUM_W-1:0] r_mem [MAX_ENTRIES];
    logic [SUM_W-1:0] r_rdata;

    logic [SIZE_W-1:0]       r_size;
    logic [AW-1:0]           r_clr_addr;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           n_idx;
    logic [SUM_W-1:0]        r_acc;
    logic [SUM_W-1:0]        n_acc;
    logic signed [AMT_W-1:0] r_amt;
    logic [RANGE_W-1:0]      r_left;
    logic                    r_type;
    logic                    r_err;
    logic                    n_err;

    logic                    r_out_valid;
    logic [SUM_W-1:0]        r_out_sum;
    logic                    r_out_err;

    logic [IW-1:0]    eff_n;
    logic [IW-1:0]    idx_m1;
    logic [AW-1:0]    mem_addr;
    logic [SUM_W-1:0] add_val;

    // size above the store acts as the store depth
    assign eff_n   = (IW'(r_size) > MAX_N) ? MAX_N : IW'(r_size);
    assign idx_m1  = r_idx - IW'(1);
    assign mem_addr = i_cmd.clr_wr ? r_clr_addr : idx_m1[AW-1:0];
    assign add_val = r_rdata + SUM_W'(r_amt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr && r_clr_addr != LAST_ADR) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[mem_addr] <= '0;
        end else if (i_cmd.add_wr) begin
            r_mem[mem_addr] <= add_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_comb begin
        n_idx = r_idx;
        n_acc = r_acc;
        n_err = r_err;
        if (i_cmd.load) begin
            n_acc = '0;
            if (i_req_type == REQ_QUERY) begin
                n_idx = IW'(i_range_right);
                n_err = (IW'(i_range_left) > eff_n) || (IW'(i_range_right) > eff_n);
            end else begin
                n_idx = IW'(i_add_position) + IW'(1);
                n_err = IW'(i_add_position) >= eff_n;
            end
        end else if (i_cmd.add_wr) begin
            // climb by lowbit
            n_idx = r_idx + (r_idx & (~r_idx + IW'(1)));
        end else if (i_cmd.acc) begin
            n_acc = i_cmd.acc_sub ? (r_acc - r_rdata) : (r_acc + r_rdata);
            // drop lowbit
            n_idx = r_idx & idx_m1;
        end else if (i_cmd.load_left) begin
            n_idx = IW'(r_left);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_acc <= n_acc;
        r_err <= n_err;
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_amt  <= i_add_amount;
            r_left <= i_range_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_out_sum <= r_acc;
            r_out_err <= r_err;
        end
    end

    assign o_status.clr_done = (r_clr_addr == LAST_ADR);
    assign o_status.err      = r_err;
    assign o_status.is_query = (r_type == REQ_QUERY);
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.idx_over = (r_idx > eff_n);

    assign o_result_valid = r_out_valid;
    assign o_range_sum    = r_out_sum;
    assign o_index_error  = r_out_err;

endmodule

// File: bench/tb_fenwick_range_sum.sv
// ============================================================================
// tb_fenwick_range_sum
// Self-checking bench for the binary indexed tree range-sum block. Point adds
// and range queries go in through the start/busy handshake. A scoreboard
// keeps its own copy of the partial-sum tree and the size register and
// predicts every strobed result. Each result is checked field by field. The
// run covers directed corner items and then random phases at several sizes.
// ============================================================================
module tb_fenwick_range_sum;
    import fwk_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 8;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             flag;
    } t_sum_result;

    // tree copy, size register and the queue of predicted results
    class t_range_sum_board;
        logic [SUM_W-1:0]  node_sum [MAX_ENTRIES_DEF];
        logic [SIZE_W-1:0] size_reg;
        t_sum_result       pending [$];
        int unsigned       mismatches;

        function new();
            foreach (node_sum[k]) node_sum[k] = '0;
            size_reg   = SIZE_RESET;
            mismatches = 0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = value;
        endfunction

        function int unsigned span();
            int unsigned n;
            n = 32'(size_reg);
            if (n > MAX_ENTRIES_DEF) n = MAX_ENTRIES_DEF;
            return n;
        endfunction

        function logic [SUM_W-1:0] prefix(int unsigned idx);
            logic [SUM_W-1:0] acc;
            acc = '0;
            while (idx > 0) begin
                acc += node_sum[idx-1];
                idx &= idx - 1;
            end
            return acc;
        endfunction

        function void note_request(logic req, logic [POS_W-1:0] pos,
                                   logic [AMT_W-1:0] amt, logic [RANGE_W-1:0] left,
                                   logic [RANGE_W-1:0] right);
            int unsigned n;
            int unsigned idx;
            t_sum_result r;
            n = span();
            r = '0;
            if (req == REQ_ADD) begin
                if (32'(pos) >= n) begin
                    r.flag = 1'b1;
                end else begin
                    idx = 32'(pos) + 1;
                    // walk upward by lowbit steps
                    while (idx <= n) begin
                        node_sum[idx-1] += {{(SUM_W-AMT_W){amt[AMT_W-1]}}, amt};
                        idx += idx & (~idx + 1);
                    end
                end
            end else if (32'(left) > n || 32'(right) > n) begin
                r.flag = 1'b1;
            end else begin
                r.sum = prefix(32'(right)) - prefix(32'(left));
            end
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR @%0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [SUM_W-1:0] sum, logic flag);
            t_sum_result want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result sum %h flag %b", sum, flag));
                return;
            end
            want = pending.pop_front();
            if (sum !== want.sum)
                report($sformatf("range_sum %h, predicted %h", sum, want.sum));
            if (flag !== want.flag)
                report($sformatf("index_error %b, predicted %b", flag, want.flag));
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_req_type;
    logic [POS_W-1:0]          i_add_position;
    logic signed [AMT_W-1:0]   i_add_amount;
    logic [RANGE_W-1:0]        i_range_left;
    logic [RANGE_W-1:0]        i_range_right;
    logic                      o_result_valid;
    logic signed [SUM_W-1:0]   o_range_sum;
    logic                      o_index_error;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [SIZE_W-1:0]         i_cfg_data;

    t_range_sum_board board;
    logic             gaps_on;
    int unsigned      cycle_count = 0;

    logic [SIZE_W-1:0] phase_size [NUM_PHASES] =
        '{11'd1024, 11'd1, 11'd2047, 11'd2, 11'd37, 11'd1000, 11'd1023, 11'd300};

    fenwick_range_sum uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_add_position (i_add_position),
        .i_add_amount   (i_add_amount),
        .i_range_left   (i_range_left),
        .i_range_right  (i_range_right),
        .o_result_valid (o_result_valid),
        .o_range_sum    (o_range_sum),
        .o_index_error  (o_index_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_fenwick_range_sum: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            board.check_result(o_range_sum, o_index_error);
    end

    task automatic scramble_payload();
        i_req_type     = $urandom_range(0, 1) ? REQ_QUERY : REQ_ADD;
        i_add_position = POS_W'($urandom);
        i_add_amount   = AMT_W'($urandom);
        i_range_left   = RANGE_W'($urandom);
        i_range_right  = RANGE_W'($urandom);
    endtask

    // present one item at the falling edge, hold until taken
    task automatic send_request(logic req, logic [POS_W-1:0] pos, logic [AMT_W-1:0] amt,
                                logic [RANGE_W-1:0] left, logic [RANGE_W-1:0] right);
        start          = 1'b1;
        i_req_type     = req;
        i_add_position = pos;
        i_add_amount   = amt;
        i_range_left   = left;
        i_range_right  = right;
        do @(posedge i_clk); while (busy);
        board.note_request(req, pos, amt, left, right);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 99) < 15) begin
            start = 1'b0;
            scramble_payload();
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    task automatic point_add(logic [POS_W-1:0] pos, logic [AMT_W-1:0] amt);
        send_request(REQ_ADD, pos, amt, RANGE_W'($urandom), RANGE_W'($urandom));
    endtask

    task automatic range_query(logic [RANGE_W-1:0] left, logic [RANGE_W-1:0] right);
        send_request(REQ_QUERY, POS_W'($urandom), AMT_W'($urandom), left, right);
    endtask

    // drain all results, then write the size register
    task automatic settle_and_write(logic [SIZE_W-1:0] value);
        start = 1'b0;
        scramble_payload();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_size(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = SIZE_W'($urandom);
    endtask

    task automatic random_item();
        int unsigned       n;
        logic [AMT_W-1:0]  amt;
        logic [POS_W-1:0]  pos;
        logic [RANGE_W-1:0] left;
        logic [RANGE_W-1:0] right;
        n = board.span();
        case ($urandom_range(0, 3))
            0:       amt = AMT_W'($urandom_range(0, 200) - 100);
            1:       amt = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: amt = AMT_W'($urandom);
        endcase
        // mostly in range, now and then anywhere the field allows
        pos   = (n > 0 && $urandom_range(0, 9) != 0) ? POS_W'($urandom_range(0, n - 1))
                                                     : POS_W'($urandom);
        left  = ($urandom_range(0, 9) != 0) ? RANGE_W'($urandom_range(0, n))
                                            : RANGE_W'($urandom);
        right = ($urandom_range(0, 9) != 0) ? RANGE_W'($urandom_range(0, n))
                                            : RANGE_W'($urandom);
        if ($urandom_range(0, 1))
            send_request(REQ_QUERY, pos, amt, left, right);
        else
            send_request(REQ_ADD, pos, amt, left, right);
    endtask

    initial begin
        board          = new();
        gaps_on        = 1'b1;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req_type     = REQ_ADD;
        i_add_position = '0;
        i_add_amount   = '0;
        i_range_left   = '0;
        i_range_right  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // full size after reset
        point_add(10'd0, 32'h7FFF_FFFF);
        point_add(10'd1023, 32'h8000_0000);
        point_add(10'd511, 32'hFFFF_FFFF);
        point_add(10'd512, 32'h1234_5678);
        range_query(11'd0, 11'd1024);
        range_query(11'd0, 11'd0);
        range_query(11'd1024, 11'd0);
        range_query(11'd1, 11'd1023);
        range_query(11'd512, 11'd513);
        range_query(11'd1025, 11'd0);
        range_query(11'd0, 11'd2047);
        range_query(11'd1024, 11'd1024);

        // shrink onto existing contents
        settle_and_write(11'd5);
        point_add(10'd4, 32'd100);
        point_add(10'd5, 32'd7);
        point_add(10'd1023, 32'd1);
        range_query(11'd0, 11'd5);
        range_query(11'd5, 11'd3);
        range_query(11'd0, 11'd6);
        range_query(11'd6, 11'd0);

        // size zero: only the empty query at zero passes
        settle_and_write(11'd0);
        point_add(10'd0, 32'd3);
        range_query(11'd0, 11'd0);
        range_query(11'd0, 11'd1);

        // size above the store clamps
        settle_and_write(11'd2047);
        range_query(11'd0, 11'd1024);
        range_query(11'd1025, 11'd1025);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_and_write(phase_size[p]);
            gaps_on = (p != 3);
            repeat (ITEMS_PER_PHASE) random_item();
        end

        start = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb_fenwick_range_sum: done, clean");
        else
            $display("tb_fenwick_range_sum: done, errors");
        $finish;
    end
endmodule

// File: files.f
+incdir+src
src/fwk_pkg.sv
src/fwk_ctrl.sv
src/fwk_dp.sv
src/fenwick_range_sum.sv
bench/tb_fenwick_range_sum.sv
